@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/zpg_pkg.sv @@
`timescale 1ns / 1ps
package zpg_pkg;

    localparam int MAX_DIM              = 4096;
    localparam int SINE_TABLE_BITS_DEF  = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS       = 3'd0,
        CFG_COLS       = 3'd1,
        CFG_ROW_RECIP  = 3'd2,
        CFG_COL_RECIP  = 3'd3,
        CFG_FREQ       = 3'd4,
        CFG_SINE_PHASE = 3'd5
    } t_cfg_index;

    localparam logic [12:0] ROWS_RST       = 13'd512;
    localparam logic [12:0] COLS_RST       = 13'd512;
    localparam logic [20:0] ROW_RECIP_RST  = 21'd4096;
    localparam logic [20:0] COL_RECIP_RST  = 21'd4096;
    localparam logic [23:0] FREQ_RST       = 24'd4194304;

    // pi/2 in Q2.30 and 1.0 in Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    // Horner divisors n*(n-1) for the odd Taylor terms
    localparam longint unsigned DIV_13 = 64'd156;
    localparam longint unsigned DIV_11 = 64'd110;
    localparam longint unsigned DIV_9  = 64'd72;
    localparam longint unsigned DIV_7  = 64'd42;
    localparam longint unsigned DIV_5  = 64'd20;
    localparam longint unsigned DIV_3  = 64'd6;

    typedef struct packed {
        logic [11:0] pos;
        logic [11:0] half;
    } t_axis;

    // Clamp an index into the image and give the half size.
    function automatic t_axis clamp_axis(input logic [11:0] idx, input logic [12:0] size);
        logic [12:0] n;
        logic [12:0] lim;
        t_axis       res;
        n = (32'(size) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : size;
        if (n == 13'd0) begin
            n = 13'd1;
        end
        lim = n - 13'd1;
        res.pos  = ({1'b0, idx} > lim) ? lim[11:0] : idx;
        res.half = n[12:1];
        return res;
    endfunction

    // Elaboration-time quarter-wave sample: angle a/2^qbits of pi/2, Q0.15 magnitude.
    function automatic logic [14:0] sine_mag(input int unsigned a, input int unsigned qbits);
        longint unsigned theta;
        longint unsigned t;
        longint unsigned h;
        longint unsigned term;
        longint unsigned s;
        longint unsigned v;
        theta = (64'(a) * HALF_PI_Q30) >> qbits;
        t     = (theta * theta) >> 30;
        h     = ONE_Q30;
        term  = ((t * h) >> 30) / DIV_13;
        h     = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
        term  = ((t * h) >> 30) / DIV_11;
        h     = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
        term  = ((t * h) >> 30) / DIV_9;
        h     = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
        term  = ((t * h) >> 30) / DIV_7;
        h     = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
        term  = ((t * h) >> 30) / DIV_5;
        h     = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
        term  = ((t * h) >> 30) / DIV_3;
        h     = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
        s     = (theta * h) >> 30;
        v     = (s + (64'd1 << 14)) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

    // Sample at exactly a quarter turn
    localparam logic [14:0] PEAK_MAG = sine_mag(32'd1, 32'd0);

endpackage

@@ src/zoneplate_pixel_generator.sv @@
// Zone plate pixel generator, ten-stage pipeline.
// Throughput: one pixel per clock; a stalled output only backs up the input
// once every stage holds a beat (empty stages collapse).
// Reset (i_rst_n low, synchronous): pipeline emptied, config registers return
// to rows=cols=512, recips=4096, freq=4194304, cosine mode.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module zoneplate_pixel_generator
    import zpg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [11:0]           i_row,
    input  logic [11:0]           i_col,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [15:0]    o_pixel_value,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NSTAGE  = 10;
    localparam int QBITS   = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QBITS;

    typedef logic [14:0] t_sine_rom [QUARTER];

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i < QUARTER; i++) begin
            rom[i] = sine_mag(32'(i), 32'(QBITS));
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    // ---------------- configuration ----------------
    logic [12:0] r_rows;
    logic [12:0] r_cols;
    logic [20:0] r_row_recip;
    logic [20:0] r_col_recip;
    logic [23:0] r_freq;
    logic        r_sine_phase;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows       <= ROWS_RST;
            r_cols       <= COLS_RST;
            r_row_recip  <= ROW_RECIP_RST;
            r_col_recip  <= COL_RECIP_RST;
            r_freq       <= FREQ_RST;
            r_sine_phase <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ROWS:       r_rows       <= i_cfg_data[12:0];
                CFG_COLS:       r_cols       <= i_cfg_data[12:0];
                CFG_ROW_RECIP:  r_row_recip  <= i_cfg_data[20:0];
                CFG_COL_RECIP:  r_col_recip  <= i_cfg_data[20:0];
                CFG_FREQ:       r_freq       <= i_cfg_data[23:0];
                CFG_SINE_PHASE: r_sine_phase <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [NSTAGE:1]   r_vld;
    logic [NSTAGE+1:1] en;

    // a stage loads when it is empty or the stage after it moves
    always_comb begin
        en[NSTAGE+1] = !i_out_stall;
        for (int k = NSTAGE; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_stall = !en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: clamp ----------------
    t_axis r_s1_y, r_s1_x;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_y <= clamp_axis(i_row, r_rows);
            r_s1_x <= clamp_axis(i_col, r_cols);
        end
    end

    // ---------------- stage 2: distance from center ----------------
    logic [11:0] n_s2_dy, n_s2_dx;
    logic [11:0] r_s2_dy, r_s2_dx;

    always_comb begin
        n_s2_dy = (r_s1_y.pos >= r_s1_y.half) ? r_s1_y.pos - r_s1_y.half
                                              : r_s1_y.half - r_s1_y.pos;
        n_s2_dx = (r_s1_x.pos >= r_s1_x.half) ? r_s1_x.pos - r_s1_x.half
                                              : r_s1_x.half - r_s1_x.pos;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_dy <= n_s2_dy;
            r_s2_dx <= n_s2_dx;
        end
    end

    // ---------------- stage 3: normalize (Q.20) ----------------
    logic [32:0] r_s3_y, r_s3_x;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_y <= 33'(r_s2_dy) * 33'(r_row_recip);
            r_s3_x <= 33'(r_s2_dx) * 33'(r_col_recip);
        end
    end

    // ---------------- stage 4: square partial products ----------------
    // v = vh*2^17 + vl, v^2 = vh^2*2^34 + vh*vl*2^18 + vl^2
    logic [31:0] r_s4_xhh, r_s4_yhh;
    logic [32:0] r_s4_xhl, r_s4_yhl;
    logic [33:0] r_s4_xll, r_s4_yll;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_xhh <= 32'(r_s3_x[32:17]) * 32'(r_s3_x[32:17]);
            r_s4_xhl <= 33'(r_s3_x[32:17]) * 33'(r_s3_x[16:0]);
            r_s4_xll <= 34'(r_s3_x[16:0]) * 34'(r_s3_x[16:0]);
            r_s4_yhh <= 32'(r_s3_y[32:17]) * 32'(r_s3_y[32:17]);
            r_s4_yhl <= 33'(r_s3_y[32:17]) * 33'(r_s3_y[16:0]);
            r_s4_yll <= 34'(r_s3_y[16:0]) * 34'(r_s3_y[16:0]);
        end
    end

    // ---------------- stage 5: squares, kept mod 2^58 ----------------
    logic [57:0] r_s5_sqx, r_s5_sqy;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s5_sqx <= {r_s4_xhh[23:0], 34'b0} + {7'b0, r_s4_xhl, 18'b0}
                      + {24'b0, r_s4_xll};
            r_s5_sqy <= {r_s4_yhh[23:0], 34'b0} + {7'b0, r_s4_yhl, 18'b0}
                      + {24'b0, r_s4_yll};
        end
    end

    // ---------------- stage 6: radius squared ----------------
    logic [57:0] r_s6_s;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6_s <= r_s5_sqx + r_s5_sqy;
        end
    end

    // ---------------- stage 7: freq * s, split in two halves ----------------
    logic [52:0] n_s7_hi_full;
    logic [52:0] r_s7_plo;
    logic [28:0] r_s7_phi;

    assign n_s7_hi_full = 53'(r_freq) * 53'(r_s6_s[57:29]);

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_s7_plo <= 53'(r_freq) * 53'(r_s6_s[28:0]);
            r_s7_phi <= n_s7_hi_full[28:0];
        end
    end

    // ---------------- stage 8: phase, quadrant ----------------
    logic [57:0]      n_s8_sum;
    logic [15:0]      n_s8_phase;
    logic [1:0]       r_s8_quad;
    logic [QBITS-1:0] r_s8_a;

    always_comb begin
        n_s8_sum   = {5'b0, r_s7_plo} + {r_s7_phi, 29'b0};
        n_s8_phase = n_s8_sum[57:42];
        // cosine is sine a quarter turn ahead
        if (!r_sine_phase) begin
            n_s8_phase[15:14] = n_s8_phase[15:14] + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_s8_quad <= n_s8_phase[15:14];
            r_s8_a    <= n_s8_phase[13 -: QBITS];
        end
    end

    // ---------------- stage 9: quarter-wave lookup ----------------
    logic [QBITS-1:0] n_s9_addr;
    logic             n_s9_peak;
    logic [14:0]      r_s9_mag;
    logic             r_s9_neg;

    always_comb begin
        // odd quadrants run backwards; a zero offset there lands on the peak
        n_s9_addr = r_s8_quad[0] ? (~r_s8_a + QBITS'(1)) : r_s8_a;
        n_s9_peak = r_s8_quad[0] && (r_s8_a == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_s9_mag <= n_s9_peak ? PEAK_MAG : SINE_ROM[n_s9_addr];
            r_s9_neg <= r_s8_quad[1];
        end
    end

    // ---------------- stage 10: sign, output register ----------------
    logic signed [15:0] n_s10_pix;
    logic signed [15:0] r_s10_pix;

    assign n_s10_pix = r_s9_neg ? -$signed({1'b0, r_s9_mag}) : $signed({1'b0, r_s9_mag});

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r_s10_pix <= n_s10_pix;
        end
    end

    assign o_out_valid   = r_vld[NSTAGE];
    assign o_pixel_value = r_s10_pix;

    // ---------------- checks ----------------
    `ASSERT_IMPLIES(a_no_min_value, i_clk, i_rst_n, o_out_valid, o_pixel_value != -16'sd32768, "pixel reached -32768")
    `ASSERT_IMPLIES(a_stall_only_full, i_clk, i_rst_n, o_in_stall, &r_vld, "input stalled with an empty stage")
    `ASSERT_IMPLIES(a_free_out_free_in, i_clk, i_rst_n, !i_out_stall, !o_in_stall, "input stalled while output drains")
    `ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_vld[1], "accepted beat lost at stage 1")

endmodule

@@ tb/zoneplate_pixel_generator_checker.sv @@
`timescale 1ns / 1ps
module zoneplate_pixel_generator_checker
    import zpg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [11:0]           i_row,
    input  logic [11:0]           i_col,

    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic signed [15:0]    i_pixel_value,

    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int              TBL_BITS     = SINE_TABLE_BITS_DEF;
    localparam int              QBITS        = TBL_BITS - 2;
    localparam longint unsigned QUARTER      = 64'd1 << QBITS;
    localparam longint unsigned UNIT_Q30     = 64'd1 << 30;
    localparam longint unsigned RIGHT_ANGLE  = 64'd1686629713;  // pi/2 in Q2.30

    typedef struct {
        logic [11:0]        row;
        logic [11:0]        col;
        logic signed [15:0] pixel;
    } t_pixel_want;

    t_pixel_want want_pixels[$];

    logic [12:0] cfg_rows;
    logic [12:0] cfg_cols;
    logic [20:0] cfg_row_recip;
    logic [20:0] cfg_col_recip;
    logic [23:0] cfg_freq;
    logic        cfg_sine;

    // |clamped index - half size| scaled by the reciprocal, Q.20
    function automatic longint unsigned axis_offset(input logic [11:0] idx,
                                                    input logic [12:0] size,
                                                    input logic [20:0] recip);
        longint unsigned n;
        longint unsigned pos;
        longint unsigned half;
        longint unsigned d;
        n = size;
        if (n > MAX_DIM) n = MAX_DIM;
        if (n == 0) n = 1;
        pos = idx;
        if (pos > n - 1) pos = n - 1;
        half = n >> 1;
        d = (pos >= half) ? pos - half : half - pos;
        return d * longint'(recip);
    endfunction

    function automatic logic signed [15:0] zone_plate_sample(input logic [11:0] row,
                                                             input logic [11:0] col);
        longint unsigned y;
        longint unsigned x;
        longint unsigned r2;
        longint unsigned turn;
        longint unsigned idx;
        longint unsigned quad;
        longint unsigned ang;
        longint unsigned theta;
        longint unsigned tsq;
        longint unsigned horner;
        longint unsigned term;
        longint unsigned sn;
        longint unsigned mag;
        int              k;
        y    = axis_offset(row, cfg_rows, cfg_row_recip);
        x    = axis_offset(col, cfg_cols, cfg_col_recip);
        r2   = x * x + y * y;
        turn = ((64'(cfg_freq) * r2) >> 42) & 64'hFFFF;
        if (!cfg_sine) turn = (turn + 64'h4000) & 64'hFFFF;
        idx  = turn >> (16 - TBL_BITS);
        quad = (idx >> QBITS) & 64'd3;
        ang  = idx & (QUARTER - 1);
        if (quad[0]) ang = QUARTER - ang;
        theta = (ang * RIGHT_ANGLE) >> QBITS;
        // odd Taylor series, Horner form, truncating at every step
        tsq    = (theta * theta) >> 30;
        horner = UNIT_Q30;
        for (k = 13; k >= 3; k -= 2) begin
            term   = ((tsq * horner) >> 30) / 64'(k * (k - 1));
            horner = (term >= UNIT_Q30) ? 64'd0 : UNIT_Q30 - term;
        end
        sn  = (theta * horner) >> 30;
        mag = (sn + (64'd1 << 14)) >> 15;
        if (mag > 64'd32767) mag = 64'd32767;
        return quad[1] ? -16'(mag) : 16'(mag);
    endfunction

    always @(posedge i_clk) begin
        t_pixel_want w;
        if (!i_rst_n) begin
            cfg_rows      = ROWS_RST;
            cfg_cols      = COLS_RST;
            cfg_row_recip = ROW_RECIP_RST;
            cfg_col_recip = COL_RECIP_RST;
            cfg_freq      = FREQ_RST;
            cfg_sine      = 1'b0;
            want_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROWS:       cfg_rows      = i_cfg_data[12:0];
                    CFG_COLS:       cfg_cols      = i_cfg_data[12:0];
                    CFG_ROW_RECIP:  cfg_row_recip = i_cfg_data[20:0];
                    CFG_COL_RECIP:  cfg_col_recip = i_cfg_data[20:0];
                    CFG_FREQ:       cfg_freq      = i_cfg_data[23:0];
                    CFG_SINE_PHASE: cfg_sine      = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (want_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel beat %0d, nothing pending",
                             $time, i_pixel_value);
                    o_fail_count++;
                end else begin
                    w = want_pixels.pop_front();
                    o_checked++;
                    if (i_pixel_value !== w.pixel) begin
                        $display("%0t: pixel mismatch at row %0d col %0d: expected %0d, actual %0d",
                                 $time, w.row, w.col, w.pixel, i_pixel_value);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                w.row   = i_row;
                w.col   = i_col;
                w.pixel = zone_plate_sample(i_row, i_col);
                want_pixels.push_back(w);
            end
        end
        o_pending = want_pixels.size();
    end

endmodule

@@ tb/zoneplate_pixel_generator_tb.sv @@
`timescale 1ns / 1ps
module zoneplate_pixel_generator_tb;
    import zpg_pkg::*;

    localparam int PIPE_DEPTH  = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 160;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [11:0]           i_row;
    logic [11:0]           i_col;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic signed [15:0]    o_pixel_value;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int   fail_count;
    int   pending;
    int   checked;
    int   cycles;
    int   settings_count;
    int   reg_writes;
    bit   quiet;

    logic [12:0] cur_rows;
    logic [12:0] cur_cols;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    zoneplate_pixel_generator #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS_DEF)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_row         (i_row),
        .i_col         (i_col),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_value (o_pixel_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    zoneplate_pixel_generator_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_pixel_value (o_pixel_value),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: timeout, %0d pixels still pending", $time, pending);
        $display("zoneplate_pixel_generator verification failed");
        $finish;
    end

    // output back-pressure: random stall bursts and calm stretches
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && i_rst_n && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 40) == 0) begin
                repeat ($urandom_range(20, 120)) @(negedge i_clk);
            end
        end
    end

    function automatic int eff_size(input logic [12:0] size);
        int n;
        n = (size > MAX_DIM) ? MAX_DIM : int'(size);
        if (n == 0) n = 1;
        return n;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        reg_writes++;
    endtask

    task automatic write_settings(input logic [23:0] rows_v, input logic [23:0] cols_v,
                                  input logic [23:0] rrec_v, input logic [23:0] crec_v,
                                  input logic [23:0] freq_v, input logic [23:0] sine_v,
                                  input bit spare);
        write_reg(CFG_ROWS, rows_v);
        write_reg(CFG_COLS, cols_v);
        write_reg(CFG_ROW_RECIP, rrec_v);
        write_reg(CFG_COL_RECIP, crec_v);
        write_reg(CFG_FREQ, freq_v);
        write_reg(CFG_SINE_PHASE, sine_v);
        if (spare) begin
            write_reg(CFG_SPARE_A, 24'($urandom));
            write_reg(CFG_SPARE_B, 24'($urandom));
        end
        i_cfg_valid <= 1'b0;
        cur_rows = rows_v[12:0];
        cur_cols = cols_v[12:0];
        settings_count++;
    endtask

    task automatic send_pixel(input logic [11:0] row, input logic [11:0] col);
        i_in_valid <= 1'b1;
        i_row      <= row;
        i_col      <= col;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // stop sending and wait for the pipeline to empty
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic pick_coord(input logic [12:0] size, output logic [11:0] idx);
        int n;
        n = eff_size(size);
        case ($urandom_range(0, 11))
            0:       idx = 12'd0;
            1:       idx = 12'hFFF;
            2:       idx = 12'($urandom);
            3:       idx = 12'(n - 1);
            default: idx = 12'($urandom_range(0, n - 1));
        endcase
    endtask

    task automatic run_phase(input int n_items, input bit hold_mid);
        logic [11:0] r;
        logic [11:0] c;
        for (int i = 0; i < n_items; i++) begin
            if (hold_mid && i == n_items / 2) begin
                drain();
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_in_valid <= 1'b0;
                i_row      <= 12'($urandom);
                i_col      <= 12'($urandom);
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            pick_coord(cur_rows, r);
            pick_coord(cur_cols, c);
            send_pixel(r, c);
        end
        drain();
    endtask

    task automatic random_settings(input int kind);
        int          hr;
        int          hc;
        logic [23:0] rows_v;
        logic [23:0] cols_v;
        logic [23:0] freq_v;
        if (kind == 2) begin
            // raw register contents, including bits above each field
            write_settings(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                           24'($urandom), 24'($urandom), 1'b1);
        end else begin
            hr = (kind == 1) ? $urandom_range(1, 4) : $urandom_range(1, 2048);
            hc = (kind == 1) ? $urandom_range(1, 4) : $urandom_range(1, 2048);
            rows_v = 24'(2 * hr + ((hr < 2048) ? $urandom_range(0, 1) : 0));
            cols_v = 24'(2 * hc + ((hc < 2048) ? $urandom_range(0, 1) : 0));
            if (kind == 3)
                freq_v = $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
            else
                freq_v = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12));
            write_settings(rows_v, cols_v,
                           24'(((1 << 20) + hr / 2) / hr), 24'(((1 << 20) + hc / 2) / hc),
                           freq_v, 24'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_row          = 12'd0;
        i_col          = 12'd0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_ROWS;
        i_cfg_data     = 24'd0;
        quiet          = 1'b0;
        settings_count = 1;
        reg_writes     = 0;
        cur_rows       = ROWS_RST;
        cur_cols       = COLS_RST;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: corners, center peak, clamped indexes
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd256, 12'd256);
        send_pixel(12'd255, 12'd256);
        send_pixel(12'd511, 12'd0);
        send_pixel(12'd0, 12'd511);
        send_pixel(12'd512, 12'd512);
        drain();

        // zero rows, cols above the max, oversized reciprocals, top frequency, sine
        write_settings(24'd0, 24'd8191, 24'h1FFFFF, 24'h1FFFFF, 24'hFFFFFF, 24'd1, 1'b1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd0, 12'd2048);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd123, 12'hFFF);
        drain();

        // 2x2 image, unit reciprocal, zero frequency, cosine
        write_settings(24'd2, 24'd2, 24'h100000, 24'h100000, 24'd0, 24'd0, 1'b0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'hFFF, 12'hFFF);
        drain();

        // largest image, matched reciprocals, unit frequency, sine
        write_settings(24'd4096, 24'd4095, 24'd512, 24'd512, 24'h010000, 24'd1, 1'b0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2048, 12'd2047);
        send_pixel(12'hFFF, 12'd4094);
        send_pixel(12'd1000, 12'd3000);
        send_pixel(12'd2048, 12'd2048);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            random_settings(p % 4);
            quiet = (p == NUM_PHASES - 1);
            run_phase(PHASE_ITEMS, p == 1);
        end

        repeat (2 * PIPE_DEPTH) @(negedge i_clk);

        $display("%0d pixels checked across %0d register settings (%0d register writes),",
                 checked, settings_count, reg_writes);
        $display("with sizes from zero to above the maximum, both waveforms and random stalls.");
        if (fail_count == 0)
            $display("zoneplate_pixel_generator verification clean");
        else
            $display("zoneplate_pixel_generator verification failed");
        $finish;
    end

endmodule
